FILE: hw/rtl/edf_ready_queue_assert.svh
// Assertion macros used by the file that checks this block.
`ifndef EDF_READY_QUEUE_ASSERT_SVH
`define EDF_READY_QUEUE_ASSERT_SVH

// A condition that implies another in the same cycle.
`define EDF_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("edf_ready_queue check failed");

// A condition that implies another in the next cycle.
`define EDF_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("edf_ready_queue check failed");

`endif

FILE: hw/rtl/edf_pkg.sv
package edf_pkg;

  localparam int NUM_TASKS = 8;
  localparam int ID_W      = $clog2(NUM_TASKS);
  localparam int LEN_W     = $clog2(NUM_TASKS + 1);
  localparam int DL_W      = 48;
  localparam int PER_W     = 32;
  localparam int CNT_W     = 32;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUEUED = 2'd1,
    ST_IDLE   = 2'd2,
    ST_BAD_ID = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  task_id;
    logic [31:0] period_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  head_task;
    logic        list_empty;
    logic [47:0] head_deadline;
    logic [31:0] completions;
    logic [1:0]  status;
  } out_item_t;

  // One task table entry.
  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [PER_W-1:0] per;
    logic [CNT_W-1:0] cnt;
  } tbl_word_t;

  // Update command to the ready list.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } list_cmd_t;

  // Ready list status: queued flags now, head after the pending command.
  typedef struct packed {
    logic                 empty;
    logic [ID_W-1:0]      head_id;
    logic [DL_W-1:0]      head_dl;
    logic [NUM_TASKS-1:0] queued;
  } list_stat_t;

endpackage

FILE: hw/rtl/edf_tbl_mem.sv
module edf_tbl_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [edf_pkg::ID_W-1:0]  rd_idx,
  output edf_pkg::tbl_word_t        rd_data,
  input  logic                      wr_en,
  input  logic [edf_pkg::ID_W-1:0]  wr_idx,
  input  edf_pkg::tbl_word_t        wr_data
);

  edf_pkg::tbl_word_t               mem [edf_pkg::NUM_TASKS];
  logic [edf_pkg::NUM_TASKS-1:0]    vld_r;
  edf_pkg::tbl_word_t               rdat_r;
  logic                             rvld_r;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[rd_idx];
    end
  end

  // Valid bits make unwritten entries read as zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : '0;

endmodule

FILE: hw/rtl/edf_rdy_list.sv
module edf_rdy_list (
  input  logic                clk,
  input  logic                rst_n,
  input  edf_pkg::list_cmd_t  cmd,
  output edf_pkg::list_stat_t stat
);

  logic [edf_pkg::ID_W-1:0]      id_r  [edf_pkg::NUM_TASKS];
  logic [edf_pkg::DL_W-1:0]      dl_r  [edf_pkg::NUM_TASKS];
  logic [edf_pkg::ID_W-1:0]      id_nxt [edf_pkg::NUM_TASKS];
  logic [edf_pkg::DL_W-1:0]      dl_nxt [edf_pkg::NUM_TASKS];
  logic [edf_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [edf_pkg::NUM_TASKS-1:0] q_r, q_nxt;
  logic [edf_pkg::LEN_W-1:0]     pos;
  logic                          after;

  // Insert after every slot with an equal or earlier deadline; remove by shifting up.
  always_comb begin
    pos   = '0;
    after = 1'b0;
    len_nxt = len_r;
    q_nxt   = q_r;
    for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
      id_nxt[i] = id_r[i];
      dl_nxt[i] = dl_r[i];
      if (edf_pkg::LEN_W'(i) < len_r && dl_r[i] <= cmd.dl) begin
        pos = pos + 1'b1;
      end
    end
    if (cmd.ins) begin
      for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
        if (edf_pkg::LEN_W'(i) == pos) begin
          id_nxt[i] = cmd.id;
          dl_nxt[i] = cmd.dl;
        end else if (edf_pkg::LEN_W'(i) > pos && i > 0) begin
          id_nxt[i] = id_r[i-1];
          dl_nxt[i] = dl_r[i-1];
        end
      end
      len_nxt       = len_r + 1'b1;
      q_nxt[cmd.id] = 1'b1;
    end else if (cmd.rem) begin
      for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
        if (edf_pkg::LEN_W'(i) < len_r && id_r[i] == cmd.id) begin
          after = 1'b1;
        end
        if (after && i + 1 < edf_pkg::NUM_TASKS) begin
          id_nxt[i] = id_r[i+1];
          dl_nxt[i] = dl_r[i+1];
        end
      end
      len_nxt       = len_r - 1'b1;
      q_nxt[cmd.id] = 1'b0;
    end
  end

  // Slot contents need no reset; the length marks what is live.
  always_ff @(posedge clk) begin
    for (int i = 0; i < edf_pkg::NUM_TASKS; i++) begin
      id_r[i] <= id_nxt[i];
      dl_r[i] <= dl_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      q_r   <= '0;
    end else begin
      len_r <= len_nxt;
      q_r   <= q_nxt;
    end
  end

  // Head reflects the list after the pending command.
  assign stat.empty   = (len_nxt == '0);
  assign stat.head_id = stat.empty ? '0 : id_nxt[0];
  assign stat.head_dl = stat.empty ? '0 : dl_nxt[0];
  assign stat.queued  = q_r;

endmodule

FILE: hw/rtl/edf_ready_queue.sv
// On acceptance, a transaction's request and task table entry are registered;
// its result is registered in the work step that follows, delayed only while an
// earlier result is held by out_stall. New transactions are stalled until then;
// the task table read comes first, then the read-modify-write plus list update.
// Reset: synchronous, active low; clears the ready list, queued flags and table
// valid bits, so every task reads as period, deadline and count zero.
module edf_ready_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  edf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output edf_pkg::out_item_t out_data
);

  logic                     busy_r;
  edf_pkg::in_item_t        req_r;
  logic                     out_valid_r;
  edf_pkg::out_item_t       out_r;
  logic                     accept, done;
  edf_pkg::tbl_word_t       rd_word, wr_word;
  logic                     wr_en;
  edf_pkg::list_cmd_t       cmd;
  edf_pkg::list_stat_t      stat;
  logic [edf_pkg::ID_W-1:0] tid;
  logic                     bad, queued;
  logic [edf_pkg::DL_W:0]   dl_sum;
  edf_pkg::status_t         status;
  logic [edf_pkg::CNT_W-1:0] count;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign done     = busy_r && (!out_valid_r || !out_stall);
  assign tid      = edf_pkg::ID_W'(req_r.task_id);

  edf_tbl_mem u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (edf_pkg::ID_W'(in_data.task_id)),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_idx  (tid),
    .wr_data (wr_word)
  );

  edf_rdy_list u_list (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Decode the request against the table entry and the queued flag.
  always_comb begin
    bad     = ({4'b0, req_r.task_id} >= 7'(edf_pkg::NUM_TASKS));
    queued  = stat.queued[tid];
    dl_sum  = {1'b0, rd_word.dl} + {17'b0, rd_word.per};
    wr_word = rd_word;
    wr_en   = 1'b0;
    cmd     = '{ins: 1'b0, rem: 1'b0, id: tid, dl: rd_word.dl};
    status  = edf_pkg::ST_OK;
    count   = rd_word.cnt;
    if (bad) begin
      status = edf_pkg::ST_BAD_ID;
      count  = '0;
    end else begin
      unique case (edf_pkg::req_t'(req_r.req_type))
        edf_pkg::REQ_LOAD: begin
          if (queued) begin
            status = edf_pkg::ST_QUEUED;
          end else begin
            wr_en       = done;
            wr_word.per = req_r.period_us;
            wr_word.dl  = {16'b0, req_r.period_us};
            wr_word.cnt = '0;
            count       = '0;
          end
        end
        edf_pkg::REQ_RELEASE: begin
          if (queued) begin
            status = edf_pkg::ST_QUEUED;
          end else begin
            cmd.ins = done;
          end
        end
        edf_pkg::REQ_COMPLETE: begin
          if (!queued) begin
            status = edf_pkg::ST_IDLE;
          end else begin
            cmd.rem    = done;
            wr_en      = done;
            wr_word.dl = dl_sum[edf_pkg::DL_W] ? '1 : dl_sum[edf_pkg::DL_W-1:0];
            if (rd_word.cnt != '1) begin
              wr_word.cnt = rd_word.cnt + 1'b1;
            end
            count = wr_word.cnt;
          end
        end
        default: begin
          status = edf_pkg::ST_OK;
        end
      endcase
    end
  end

  // Request register: holds the accepted transaction through its work cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (done) begin
      out_r.head_task     <= 3'(stat.head_id);
      out_r.list_empty    <= stat.empty;
      out_r.head_deadline <= stat.head_dl;
      out_r.completions   <= count;
      out_r.status        <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "edf_ready_queue_assert.svh"

  `EDF_ASSERT_NEXT(a_accept_busy, accept, busy_r)
  `EDF_ASSERT_NOW(a_empty_dl, out_valid_r && out_r.list_empty, out_r.head_deadline == '0)
  `EDF_ASSERT_NEXT(a_done_result, done, out_valid_r && !busy_r)

endmodule
